[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared macros for the concurrent checks of the COBS frame encoder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// A condition that, once seen, forces another one in the next cycle.
`define ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

[src/cobs_pkg.sv]
// ----------------------------------------------------------------------------
// COBS encoder package
// Word types, queue sizing, byte codes and pointer arithmetic of the encoder.
// ----------------------------------------------------------------------------
package cobs_pkg;

	// Queue sizing.
	localparam int QUEUE_DEPTH = 512;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	// Longest run of nonzero bytes in one group.
	localparam int MAX_GROUP = 254;

	// Command codes.
	localparam logic [1:0] MODE_PUSH = 2'd0;
	localparam logic [1:0] MODE_END  = 2'd1;
	localparam logic [1:0] MODE_PULL = 2'd2;

	// Byte codes.
	localparam logic [7:0] BYTE_DELIM      = 8'h00;
	localparam logic [7:0] BYTE_EMPTY_CODE = 8'h01;
	localparam logic [7:0] BYTE_FULL_CODE  = 8'(MAX_GROUP + 1);

	typedef logic [PTR_W-1:0] ptr_t;
	typedef logic [CNT_W-1:0] cnt_t;

	// Command word.
	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] in_byte;
	} cmd_t;

	// Response word.
	typedef struct packed {
		logic       out_valid;
		logic [7:0] out_byte;
		logic       frame_end;
		logic       overflow;
	} rsp_t;

	// One queue write.
	typedef struct packed {
		ptr_t       addr;
		logic [7:0] data;
	} wr_t;

	// Advance a queue pointer by zero to three entries with wrap.
	function automatic ptr_t ptr_add(input ptr_t p, input logic [1:0] k);
		logic [PTR_W:0] s;
		s = {1'b0, p} + (PTR_W + 1)'(k);
		if (s >= (PTR_W + 1)'(QUEUE_DEPTH)) begin
			s = s - (PTR_W + 1)'(QUEUE_DEPTH);
		end
		return s[PTR_W-1:0];
	endfunction

endpackage

[src/cobs_frame_encoder.sv]
// ----------------------------------------------------------------------------
// COBS frame encoder
// Streaming COBS encoder that builds delimited frames in an output queue.
// ----------------------------------------------------------------------------
// Usage:
// The cmd channel carries one command word per transfer: push a packet byte,
// end the packet, or pull one encoded byte. Every accepted command returns
// exactly one word on the rsp channel, in order. A pull returns the next
// committed queue byte, or out_valid low when the queue is empty or the open
// group holds it back. A push or end with fewer than three free queue entries
// is refused with overflow set and leaves the queue untouched.
// A command goes through the read stage and the response register. Pushes
// inside a group and pulls run at one word per cycle while rsp_stall is low.
// The queue has a single write port, so a command that writes more than one
// byte holds cmd_stall for the extra writes: a push at a packet start, a push
// that fills its group to the maximum length, or an end inside an open group
// writes two bytes, and an end with no packet open (00 01 00) writes three.
// When rsp_stall is high the response register holds, one more word waits in
// the read stage, and then cmd_stall rises. Reset clears the pointers, the
// counters and the packet state; queue contents are never cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cobs_frame_encoder (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_stall,
	input  cobs_pkg::cmd_t  cmd,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output cobs_pkg::rsp_t  rsp
);

	// Queue storage.
	logic [7:0] mem_q [cobs_pkg::QUEUE_DEPTH];

	// Encoder state.
	cobs_pkg::ptr_t wp_q, rp_q, slot_q;
	cobs_pkg::cnt_t fill_q;
	logic [7:0]     glen_q;
	logic           in_pkt_q, grp_open_q;

	// Extra writes still owed by the last command.
	cobs_pkg::wr_t  pend0_q, pend1_q;
	logic [1:0]     pcnt_q;

	// Read stage and response register.
	logic           vld_s1, hit_s1, ovf_s1;
	logic [7:0]     rd_s1;
	logic           res_vld_q, rif_q;
	cobs_pkg::rsp_t res_q;

	// Command decode and next state.
	logic           accept, is_push, is_end, is_pull, room_ok, pull_hit, overflow;
	logic           start, gopen_eff, byte_zero, grp_full;
	logic [1:0]     kpre, adv;
	cobs_pkg::ptr_t slot_eff, data_addr;
	logic [7:0]     glen_eff, glen_inc;
	cobs_pkg::ptr_t slot_n;
	logic [7:0]     glen_n;
	logic           in_pkt_n, gopen_n;
	logic           en_a, en_b, en_c;
	cobs_pkg::wr_t  cand_a, cand_b, cand_c, w0, w1;
	logic [1:0]     wcnt;

	// Write port and pipeline control.
	logic           wr_en;
	cobs_pkg::wr_t  wr;
	logic           out_ld, s1_free;
	cobs_pkg::cnt_t occ_chk, depth_chk;

	// Handshake: the read stage frees up when its word moves to the output.
	assign out_ld    = vld_s1 && (!res_vld_q || !rsp_stall);
	assign s1_free   = !vld_s1 || out_ld;
	assign cmd_stall = (pcnt_q != 2'd0) || !s1_free;
	assign accept    = cmd_valid && !cmd_stall;

	// Command classification and queue room.
	assign is_push  = (cmd.mode == cobs_pkg::MODE_PUSH);
	assign is_end   = (cmd.mode == cobs_pkg::MODE_END);
	assign is_pull  = (cmd.mode == cobs_pkg::MODE_PULL);
	assign room_ok  = fill_q <= cobs_pkg::cnt_t'(cobs_pkg::QUEUE_DEPTH - 3);
	assign overflow = (is_push || is_end) && !room_ok;
	// Bytes up to the open code slot are committed.
	assign pull_hit = is_pull && (grp_open_q ? (slot_q != rp_q) : (fill_q != '0));

	// Push addressing: an optional opening delimiter, then the code slot.
	// The slot itself is only reserved here; its value is written on patch.
	assign start     = !in_pkt_q;
	assign gopen_eff = in_pkt_q && grp_open_q;
	assign kpre      = {1'b0, start} + {1'b0, !gopen_eff};
	assign slot_eff  = gopen_eff ? slot_q : cobs_pkg::ptr_add(wp_q, {1'b0, start});
	assign data_addr = cobs_pkg::ptr_add(wp_q, kpre);
	assign glen_eff  = gopen_eff ? glen_q : 8'd0;
	assign glen_inc  = glen_eff + 8'd1;
	assign byte_zero = (cmd.in_byte == 8'd0);
	assign grp_full  = !byte_zero && (glen_inc >= 8'(cobs_pkg::MAX_GROUP));

	// Next state and up to three candidate queue writes.
	always_comb begin
		en_a     = 1'b0;
		en_b     = 1'b0;
		en_c     = 1'b0;
		cand_a   = '{addr: wp_q, data: cobs_pkg::BYTE_DELIM};
		cand_b   = '{addr: data_addr, data: cmd.in_byte};
		cand_c   = '{addr: slot_eff, data: glen_inc};
		adv      = 2'd0;
		slot_n   = slot_q;
		glen_n   = glen_q;
		in_pkt_n = in_pkt_q;
		gopen_n  = grp_open_q;
		if (is_push && room_ok) begin
			// Delimiter on a packet start, data byte, and a slot patch when the
			// group closes on a zero or on reaching its maximum length.
			en_a     = start;
			en_b     = !byte_zero;
			en_c     = byte_zero || grp_full;
			cand_c   = '{addr: slot_eff,
				data: byte_zero ? glen_inc : cobs_pkg::BYTE_FULL_CODE};
			adv      = kpre + 2'd1;
			in_pkt_n = 1'b1;
			if (byte_zero) begin
				slot_n  = data_addr;
				glen_n  = 8'd0;
				gopen_n = 1'b1;
			end else if (grp_full) begin
				slot_n  = slot_eff;
				glen_n  = 8'd0;
				gopen_n = 1'b0;
			end else begin
				slot_n  = slot_eff;
				glen_n  = glen_inc;
				gopen_n = 1'b1;
			end
		end else if (is_end && room_ok) begin
			if (in_pkt_q) begin
				// Patch the open slot, then the closing delimiter.
				en_a   = grp_open_q;
				cand_a = '{addr: slot_q, data: glen_q + 8'd1};
				en_b   = 1'b1;
				cand_b = '{addr: wp_q, data: cobs_pkg::BYTE_DELIM};
				adv    = 2'd1;
			end else begin
				// Empty packet frame.
				en_a   = 1'b1;
				en_b   = 1'b1;
				en_c   = 1'b1;
				cand_b = '{addr: cobs_pkg::ptr_add(wp_q, 2'd1),
					data: cobs_pkg::BYTE_EMPTY_CODE};
				cand_c = '{addr: cobs_pkg::ptr_add(wp_q, 2'd2),
					data: cobs_pkg::BYTE_DELIM};
				adv    = 2'd3;
			end
			in_pkt_n = 1'b0;
			gopen_n  = 1'b0;
			glen_n   = 8'd0;
		end
	end

	// Pack the enabled writes into issue order.
	assign w0   = en_a ? cand_a : (en_b ? cand_b : cand_c);
	assign w1   = (en_a && en_b) ? cand_b : cand_c;
	assign wcnt = {1'b0, en_a} + {1'b0, en_b} + {1'b0, en_c};

	// Single write port: owed writes go first, the command's first write
	// goes in its accept cycle.
	assign wr_en = (pcnt_q != 2'd0) || (accept && (wcnt != 2'd0));
	assign wr    = (pcnt_q != 2'd0) ? pend0_q : w0;

	// Queue memory write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	// Queue memory read port, registered in the read stage.
	always_ff @(posedge clk) begin
		if (accept && pull_hit) begin
			rd_s1 <= mem_q[rp_q];
		end
	end

	// Owed writes: hold the remainder of a multi-byte command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcnt_q <= 2'd0;
		end else if (pcnt_q != 2'd0) begin
			pcnt_q <= pcnt_q - 2'd1;
		end else if (accept && (wcnt > 2'd1)) begin
			pcnt_q <= wcnt - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pcnt_q != 2'd0) begin
			pend0_q <= pend1_q;
		end else if (accept) begin
			pend0_q <= w1;
			pend1_q <= cand_c;
		end
	end

	// Encoder state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q       <= '0;
			rp_q       <= '0;
			fill_q     <= '0;
			slot_q     <= '0;
			glen_q     <= 8'd0;
			in_pkt_q   <= 1'b0;
			grp_open_q <= 1'b0;
		end else if (accept) begin
			wp_q       <= cobs_pkg::ptr_add(wp_q, adv);
			slot_q     <= slot_n;
			glen_q     <= glen_n;
			in_pkt_q   <= in_pkt_n;
			grp_open_q <= gopen_n;
			if (pull_hit) begin
				rp_q   <= cobs_pkg::ptr_add(rp_q, 2'd1);
				fill_q <= fill_q - cobs_pkg::cnt_t'(1);
			end else begin
				fill_q <= fill_q + cobs_pkg::cnt_t'(adv);
			end
		end
	end

	// Read stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s1_free) begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hit_s1 <= pull_hit;
			ovf_s1 <= overflow;
		end
	end

	// Response register and read-side frame tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
			rif_q     <= 1'b0;
		end else begin
			if (out_ld) begin
				res_vld_q <= 1'b1;
			end else if (!rsp_stall) begin
				res_vld_q <= 1'b0;
			end
			if (out_ld && hit_s1 && (rd_s1 == cobs_pkg::BYTE_DELIM)) begin
				rif_q <= !rif_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld) begin
			res_q.out_valid <= hit_s1;
			res_q.out_byte  <= hit_s1 ? rd_s1 : 8'd0;
			res_q.frame_end <= hit_s1 && (rd_s1 == cobs_pkg::BYTE_DELIM) && rif_q;
			res_q.overflow  <= ovf_s1;
		end
	end

	assign rsp_valid = res_vld_q;
	assign rsp       = res_q;

	// Occupancy implied by the pointers, for the checks below.
	assign depth_chk = cobs_pkg::cnt_t'(cobs_pkg::QUEUE_DEPTH);

	always_comb begin
		if (wp_q >= rp_q) begin
			occ_chk = cobs_pkg::cnt_t'(wp_q) - cobs_pkg::cnt_t'(rp_q);
		end else begin
			occ_chk = cobs_pkg::cnt_t'(wp_q) + cobs_pkg::cnt_t'(cobs_pkg::QUEUE_DEPTH)
				- cobs_pkg::cnt_t'(rp_q);
		end
	end

	// Checks.
	`ASSERT_ALWAYS(a_fill_range, fill_q <= depth_chk, "fill count beyond queue depth")
	`ASSERT_ALWAYS(a_fill_ptrs, (fill_q == occ_chk) || ((fill_q == depth_chk) && (wp_q == rp_q)), "fill count disagrees with pointers")
	`ASSERT_ALWAYS(a_group_in_pkt, !grp_open_q || in_pkt_q, "group open outside a packet")
	`ASSERT_NEXT(a_pend_drain, pcnt_q == 2'd2, pcnt_q == 2'd1, "owed writes did not drain")

endmodule
